// ----- hw/rtl/rpmbar_pkg.sv -----
// Shared widths, register indexes and reset values for the tachometer bar block.
package rpmbar_pkg;

  localparam int SPEED_W = 16;
  localparam int BYTE_W = 8;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOW_LIMIT    = 3'd0,
    CFG_HIGH_LIMIT   = 3'd1,
    CFG_FLASH_LIMIT  = 3'd2,
    CFG_BAND         = 3'd3,
    CFG_BLINK_PERIOD = 3'd4,
    CFG_DUTY_NORMAL  = 3'd5,
    CFG_DUTY_FLASH   = 3'd6
  } cfg_idx_t;

  localparam logic [SPEED_W-1:0] LOW_LIMIT_RST = 16'd4000;
  localparam logic [SPEED_W-1:0] HIGH_LIMIT_RST = 16'd7000;
  localparam logic [SPEED_W-1:0] FLASH_LIMIT_RST = 16'd7000;
  localparam logic [SPEED_W-1:0] BAND_RST = 16'd250;
  localparam logic [BYTE_W-1:0] BLINK_PERIOD_RST = 8'd25;
  localparam logic [BYTE_W-1:0] DUTY_NORMAL_RST = 8'd8;
  localparam logic [BYTE_W-1:0] DUTY_FLASH_RST = 8'd64;
  localparam logic [SPEED_W-1:0] SPEED_MAX = 16'hffff;

endpackage

// ----- hw/rtl/rpm_led_bar_with_shift_flash_core.sv -----
// Top level of the tachometer LED bar graph with shift-light flash.
// One speed beat in gives one result beat out (bar_mask, duty). The block works
// on one sample at a time. The bit-serial divider, with QW = $clog2(BAR_LEDS + 1)
// quotient bits, forms the lit count floor(BAR_LEDS * (shown - low_limit) /
// (high_limit - low_limit)); shown speeds below low_limit or above high_limit
// skip it, as does a shown speed at low_limit, which lights one LED. The
// displayed speed follows a sample only when it leaves the band around the
// current value (the lower edge clamps at zero, the upper edge saturates).
// At or above flash_limit the duty is duty_flash and the bar blinks,
// toggling every blink_period + 1 samples; otherwise the bar is steady at
// duty_normal. The result register lets a new sample be taken while the
// previous result waits on out_ready. Configuration writes are always ready
// and must only be issued while idle; writes to an index past the list are
// dropped.
module rpm_led_bar_with_shift_flash_core #(
  parameter int BAR_LEDS = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [rpmbar_pkg::SPEED_W-1:0]   speed,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [rpmbar_pkg::BYTE_W-1:0]    bar_mask,
  output logic [rpmbar_pkg::BYTE_W-1:0]    duty,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rpmbar_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rpmbar_pkg::SPEED_W-1:0]   cfg_data
);
  import rpmbar_pkg::*;

  localparam int NW = $clog2(BAR_LEDS + 1);
  localparam int DW = SPEED_W + NW;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TRACK,
    ST_CLASS,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t state;

  // configuration registers
  logic [SPEED_W-1:0] low_limit;
  logic [SPEED_W-1:0] high_limit;
  logic [SPEED_W-1:0] flash_limit;
  logic [SPEED_W-1:0] band;
  logic [BYTE_W-1:0]  blink_period;
  logic [BYTE_W-1:0]  duty_normal;
  logic [BYTE_W-1:0]  duty_flash;

  // running state
  logic [SPEED_W-1:0] shown_speed;
  logic [BYTE_W-1:0]  blink_count;
  logic               blink_on;

  // per-sample work registers
  logic [SPEED_W-1:0] spd;
  logic [BYTE_W-1:0]  duty_sel;
  logic [NW-1:0]      lit;

  // hysteresis band edges
  logic [SPEED_W:0]   upper_sum;
  logic [SPEED_W-1:0] upper;
  logic [SPEED_W-1:0] lower;
  logic               follow;

  // divider hookup
  logic               div_start;
  logic [DW-1:0]      div_dividend;
  logic               div_done;
  logic [NW-1:0]      div_quot;

  logic [BYTE_W-1:0]  therm;
  logic               out_free;

  assign in_ready = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free = !out_valid || out_ready;

  assign upper_sum = {1'b0, shown_speed} + {1'b0, band};
  assign upper = upper_sum[SPEED_W] ? SPEED_MAX : upper_sum[SPEED_W-1:0];
  assign lower = (shown_speed > band) ? (shown_speed - band) : '0;
  assign follow = (spd > upper) || (spd < lower);

  // product fits: shown - low <= 65535, times BAR_LEDS < 2^NW
  assign div_dividend = DW'(shown_speed - low_limit) * DW'(BAR_LEDS);
  assign div_start = (state == ST_CLASS) && (shown_speed > low_limit) &&
                     (shown_speed <= high_limit);

  // thermometer code of the lit count, cut to the bar field
  always_comb begin
    for (int b = 0; b < BYTE_W; b++) begin
      therm[b] = (32'(lit) > b);
    end
  end

  rpmbar_div #(
    .QW(NW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (high_limit - low_limit),
    .done     (div_done),
    .quot     (div_quot)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      low_limit <= LOW_LIMIT_RST;
      high_limit <= HIGH_LIMIT_RST;
      flash_limit <= FLASH_LIMIT_RST;
      band <= BAND_RST;
      blink_period <= BLINK_PERIOD_RST;
      duty_normal <= DUTY_NORMAL_RST;
      duty_flash <= DUTY_FLASH_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_LOW_LIMIT:    low_limit <= cfg_data;
        CFG_HIGH_LIMIT:   high_limit <= cfg_data;
        CFG_FLASH_LIMIT:  flash_limit <= cfg_data;
        CFG_BAND:         band <= cfg_data;
        CFG_BLINK_PERIOD: blink_period <= cfg_data[BYTE_W-1:0];
        CFG_DUTY_NORMAL:  duty_normal <= cfg_data[BYTE_W-1:0];
        CFG_DUTY_FLASH:   duty_flash <= cfg_data[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  // sample sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
      shown_speed <= '0;
      blink_count <= '0;
      blink_on <= 1'b1;
    end else begin
      // drop the result beat once the consumer takes it, unless a new one loads
      if (out_valid && out_ready && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            spd <= speed;
            state <= ST_TRACK;
          end
        end
        ST_TRACK: begin
          // follow the sample only when it leaves the band
          if (follow) begin
            shown_speed <= spd;
          end
          // blink state advances before the mask is formed
          if (spd >= flash_limit) begin
            duty_sel <= duty_flash;
            if (blink_count == blink_period) begin
              blink_count <= '0;
              blink_on <= !blink_on;
            end else begin
              blink_count <= blink_count + 8'd1;
            end
          end else begin
            duty_sel <= duty_normal;
            blink_on <= 1'b1;
          end
          state <= ST_CLASS;
        end
        ST_CLASS: begin
          if (shown_speed < low_limit) begin
            lit <= '0;
            state <= ST_DONE;
          end else if (shown_speed == low_limit) begin
            lit <= NW'(1);
            state <= ST_DONE;
          end else if (shown_speed > high_limit) begin
            lit <= NW'(BAR_LEDS);
            state <= ST_DONE;
          end else begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            lit <= div_quot;
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          // hold until the result register is free
          if (out_free) begin
            bar_mask <= blink_on ? therm : '0;
            duty <= duty_sel;
            out_valid <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/rpmbar_div.sv -----
// Restoring divider that develops one quotient bit per cycle.
module rpmbar_div #(
  parameter int QW = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [rpmbar_pkg::SPEED_W+QW-1:0] dividend,
  input  logic [rpmbar_pkg::SPEED_W-1:0]    divisor,
  output logic                             done,
  output logic [QW-1:0]                    quot
);
  import rpmbar_pkg::*;

  localparam int DW = SPEED_W + QW;
  localparam int CNT_W = $clog2(QW + 1);

  logic [DW-1:0]    rem;
  logic [DW-1:0]    dv;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             ge;
  logic [QW:0]      qs;

  assign ge = (rem >= dv);
  assign qs = {quot, ge};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
      done <= 1'b0;
    end else if (start) begin
      rem <= dividend;
      dv <= DW'(divisor) << (QW - 1);
      quot <= '0;
      cnt <= CNT_W'(QW);
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy) begin
      // subtract the aligned divisor when it fits, then slide it one place down
      if (ge) begin
        rem <= rem - dv;
      end
      quot <= qs[QW-1:0];
      dv <= dv >> 1;
      cnt <= cnt - CNT_W'(1);
      done <= (cnt == CNT_W'(1));
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end else begin
      done <= 1'b0;
    end
  end

endmodule
